/* rtl/core/wrv_pkg.sv */
package wrv_pkg;

  localparam int MAX_SAMPLES = 262144;
  localparam int FRAC_BITS   = 16;

  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int XS_W     = SAMPLE_W + FRAC_BITS;     // scaled sample
  localparam int MEAN_W   = XS_W + 1;                 // running mean, signed
  localparam int DIFF_W   = MEAN_W + 1;               // signed difference
  localparam int MAG_W    = DIFF_W - 1;               // magnitude of a difference
  localparam int M2_W     = 64;
  localparam int VAR_W    = 46;

  // shared restoring divider
  localparam int DIV_W  = M2_W;
  localparam int STEP_W = $clog2(DIV_W + 1);

  // two-pass multiplier
  localparam int MUL_LO_W = (MAG_W + 1) / 2;
  localparam int MUL_HI_W = MAG_W - MUL_LO_W;
  localparam int PP_W     = MAG_W + MUL_LO_W;
  localparam int FULLP_W  = 2 * MAG_W;
  localparam int PROD_W   = FULLP_W - FRAC_BITS;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

/* rtl/core/wrv_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// The dividend is loaded left-aligned; once done is raised the quotient
// sits in the low bits of the shift register (upper bits are zero).
module wrv_div import wrv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quotient
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [CNT_W-1:0]  rem;
  logic [DIV_W-1:0]  q;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  assign trial = {rem, q[DIV_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = ~diff[CNT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
        rem  <= '0;
        q    <= dividend;
      end else if (busy) begin
        q   <= {q[DIV_W-2:0], fits};
        rem <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;

endmodule

/* rtl/core/wrv_mul.sv */
// Unsigned magnitude product, scaled down by the fraction bits.
// One narrow multiplier used twice (low half of b, then high half).
module wrv_mul import wrv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MAG_W-1:0]  a,
  input  logic [MAG_W-1:0]  b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LO   = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_SUM  = 2'd3;

  logic [1:0]          ph;
  logic [MAG_W-1:0]    a_r;
  logic [MAG_W-1:0]    b_r;
  logic [MUL_LO_W-1:0] b_sel;
  logic [PP_W-1:0]     pp;
  logic [PP_W-1:0]     acc_lo;
  logic [FULLP_W-1:0]  full;

  assign b_sel = (ph == PH_LO) ? b_r[MUL_LO_W-1:0]
                               : MUL_LO_W'(b_r[MAG_W-1:MUL_LO_W]);
  assign full  = FULLP_W'(acc_lo) + (FULLP_W'(pp) << MUL_LO_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= PH_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (ph)
        PH_IDLE: begin
          if (start) begin
            a_r <= a;
            b_r <= b;
            ph  <= PH_LO;
          end
        end
        PH_LO: begin
          pp <= PP_W'(a_r) * PP_W'(b_sel);
          ph <= PH_HI;
        end
        PH_HI: begin
          acc_lo <= pp;
          pp     <= PP_W'(a_r) * PP_W'(b_sel);
          ph     <= PH_SUM;
        end
        PH_SUM: begin
          prod <= full[FULLP_W-1:FRAC_BITS];
          done <= 1'b1;
          ph   <= PH_IDLE;
        end
        default: ph <= PH_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/welford_running_variance_core.sv */
// A sample with last low keeps the core busy after its accept until its M2 update;
//   the 33 quotient bits of the mean update through the radix-2 divider dominate.
// A sample with last high adds a 64-bit M2 / count on the same divider, so its
//   result is registered later, and later still while the previous one is unread.
// The core takes a new sample only once it is through with the previous one.
// Reset (rst, synchronous): count, mean, M2, overflow flag and out_valid cleared; state idle.
module welford_running_variance_core import wrv_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [VAR_W-1:0]           variance,
  output logic [CNT_W-1:0]           sample_count,
  output logic                       overflow
);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DELTA  = 4'd1;   // delta = X - mean
  localparam logic [3:0] S_DSTART = 4'd2;   // launch |delta| / n
  localparam logic [3:0] S_DWAIT  = 4'd3;
  localparam logic [3:0] S_MEAN   = 4'd4;   // mean += trunc(delta / n)
  localparam logic [3:0] S_AFTER  = 4'd5;   // X - new mean
  localparam logic [3:0] S_MSTART = 4'd6;
  localparam logic [3:0] S_MWAIT  = 4'd7;
  localparam logic [3:0] S_ACC    = 4'd8;   // M2 += product, saturating
  localparam logic [3:0] S_VSTART = 4'd9;   // launch M2 / n
  localparam logic [3:0] S_VWAIT  = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;  // load result register, clear set

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  logic [3:0] state;

  // set state
  logic [CNT_W-1:0]         count;
  logic signed [MEAN_W-1:0] mean;
  logic [M2_W-1:0]          m2;
  logic                     saturated;

  // per-request working registers
  logic signed [SAMPLE_W-1:0] x_r;
  logic                       last_r;
  logic [MAG_W-1:0]           dmag;
  logic                       dneg;
  logic [MAG_W-1:0]           amag;

  // datapath
  logic signed [DIFF_W-1:0] xs_ext;
  logic signed [DIFF_W-1:0] delta;
  logic signed [DIFF_W-1:0] delta_neg;
  logic signed [DIFF_W-1:0] step;
  logic signed [DIFF_W-1:0] mean_sum;
  logic signed [DIFF_W-1:0] after;
  logic signed [DIFF_W-1:0] after_neg;
  logic [M2_W:0]            m2_sum;

  // shared divider
  div_req_t         div_req;
  logic [DIV_W-1:0] div_dividend;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;

  // multiplier
  logic              mul_start;
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;

  assign in_ready = (state == S_IDLE);

  // X = x * 2^FRAC_BITS, sign-extended to difference width
  assign xs_ext    = DIFF_W'($signed({x_r, {FRAC_BITS{1'b0}}}));
  assign delta     = xs_ext - DIFF_W'(mean);
  assign delta_neg = -delta;

  // trunc toward zero: divide magnitudes, restore the sign
  assign step     = dneg ? -DIFF_W'(div_quot[MAG_W-1:0]) : DIFF_W'(div_quot[MAG_W-1:0]);
  assign mean_sum = DIFF_W'(mean) + step;

  assign after     = xs_ext - DIFF_W'(mean);
  assign after_neg = -after;

  assign m2_sum = {1'b0, m2} + (M2_W + 1)'(mul_prod);

  // Divider operand: |delta| left-aligned for the mean step, M2 for the variance
  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = STEP_W'(MAG_W);
    div_dividend  = {dmag, {(DIV_W - MAG_W){1'b0}}};
    case (state)
      S_DSTART: div_req.start = 1'b1;
      S_VSTART: begin
        div_req.start = 1'b1;
        div_req.steps = STEP_W'(DIV_W);
        div_dividend  = m2;
      end
      default: ;
    endcase
  end

  assign mul_start = (state == S_MSTART);

  wrv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quot)
  );

  wrv_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (dmag),
    .b     (amag),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      mean      <= '0;
      m2        <= '0;
      saturated <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drained; a reload in S_OUT sets it again instead
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x_r    <= sample;
            last_r <= last;
            // n = count + 1, held at the limit once reached
            if (count >= CNT_MAX) begin
              count     <= CNT_MAX;
              saturated <= 1'b1;
            end else begin
              count <= count + 1'b1;
            end
            state <= S_DELTA;
          end
        end
        S_DELTA: begin
          dneg  <= delta[DIFF_W-1];
          dmag  <= delta[DIFF_W-1] ? delta_neg[MAG_W-1:0] : delta[MAG_W-1:0];
          state <= S_DSTART;
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          mean  <= mean_sum[MEAN_W-1:0];
          state <= S_AFTER;
        end
        S_AFTER: begin
          amag  <= after[DIFF_W-1] ? after_neg[MAG_W-1:0] : after[MAG_W-1:0];
          state <= S_MSTART;
        end
        S_MSTART: state <= S_MWAIT;
        S_MWAIT: begin
          if (mul_done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          m2    <= m2_sum[M2_W] ? {M2_W{1'b1}} : m2_sum[M2_W-1:0];
          state <= last_r ? S_VSTART : S_IDLE;
        end
        S_VSTART: state <= S_VWAIT;
        S_VWAIT: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // wait until the result register is free or being drained
          if (!out_valid || out_ready) begin
            variance     <= (|div_quot[DIV_W-1:VAR_W]) ? {VAR_W{1'b1}}
                                                       : div_quot[VAR_W-1:0];
            sample_count <= count;
            overflow     <= saturated;
            out_valid    <= 1'b1;
            count        <= '0;
            mean         <= '0;
            m2           <= '0;
            saturated    <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Count never runs past the saturation limit
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("count above limit");

  // Overflow flag only ever set with the count pinned at the limit
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    saturated |-> (count == CNT_MAX))
    else $error("saturated without full count");

  // One request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accept");

  // Issuing a result empties the set state
  a_clear_on_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!out_valid || out_ready)) |=>
      (out_valid && count == '0 && m2 == '0 && !saturated))
    else $error("set state not cleared after result");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import wrv_pkg::*;

  // Cycles without any accepted request before the run is declared hung.
  // Worst legal gap: the long output hold-off (HOLD_CYCLES) plus a closing
  // sample plus the sender's longest idle gap.
  localparam int HANG_LIMIT   = 6000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int HOLD_AFTER   = 10;     // results seen before the long hold-off
  localparam int RANDOM_ITEMS = 700;
  localparam int DRAIN_CYCLES = 250;

  localparam logic [63:0] VAR_MAX = (64'd1 << VAR_W) - 64'd1;

  typedef struct packed {
    logic [VAR_W-1:0] variance;
    logic [CNT_W-1:0] cnt;
    logic             ovf;
  } stats_t;

  // One row of the directed table. When 'typed' is set, 'want' holds the
  // hand-computed result; otherwise the predictor supplies it.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       lst;
    logic                       typed;
    stats_t                     want;
  } row_t;

  localparam stats_t NONE = '0;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic                       out_valid;
  logic                       out_ready;
  logic [VAR_W-1:0]           variance;
  logic [CNT_W-1:0]           sample_count;
  logic                       overflow;

  welford_running_variance_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .variance     (variance),
    .sample_count (sample_count),
    .overflow     (overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: a private copy of the running statistics.
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] run_count = '0;
  longint           run_mean  = 0;     // signed, FRAC_BITS fraction bits
  logic [63:0]      run_m2    = '0;    // unsigned, FRAC_BITS fraction bits
  logic             run_sat   = 1'b0;

  stats_t stats_expected_q[$];
  stats_t got_front;
  int     mismatches = 0;
  int     results_seen = 0;
  int     hang_cycles = 0;

  // Sender pacing
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Folds one sample into the running statistics by Welford's rule.
  // Returns 1 and fills 'res' when the sample closes a set.
  function automatic logic welford_fold(input logic signed [SAMPLE_W-1:0] smp,
                                        input logic lst, output stats_t res);
    longint       xs;
    longint       delta;
    longint       after;
    logic [127:0] wide;
    logic [63:0]  prod;
    logic [63:0]  quo;
    logic [64:0]  acc;
    xs = longint'(smp) <<< FRAC_BITS;
    // count sticks at MAX_SAMPLES; the sample is still folded in
    if (run_count >= MAX_SAMPLES) begin
      run_count = CNT_W'(MAX_SAMPLES);
      run_sat   = 1'b1;
    end else begin
      run_count = run_count + 1'b1;
    end
    delta    = xs - run_mean;
    run_mean = run_mean + delta / longint'(run_count);   // truncates toward zero
    after    = xs - run_mean;
    // factors never differ in sign, so |a|*|b| is the product; exact in 128 bits
    wide = {64'd0, magnitude(delta)} * {64'd0, magnitude(after)};
    wide = wide >> FRAC_BITS;
    prod = (wide[127:64] != '0) ? '1 : wide[63:0];
    acc  = {1'b0, run_m2} + {1'b0, prod};
    run_m2 = acc[64] ? '1 : acc[63:0];
    res = '0;
    if (!lst) return 1'b0;
    quo = run_m2 / 64'(run_count);
    res.variance = (quo > VAR_MAX) ? VAR_MAX[VAR_W-1:0] : quo[VAR_W-1:0];
    res.cnt      = run_count;
    res.ovf      = run_sat;
    run_count = '0;
    run_mean  = 0;
    run_m2    = '0;
    run_sat   = 1'b0;
    return 1'b1;
  endfunction

  // Offers one request, waits for it to be taken, records the expected
  // result, then maybe idles. Valid stays high across back-to-back requests.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst,
                             input logic typed, input stats_t want);
    stats_t res;
    logic   closes;
    in_valid <= 1'b1;
    sample   <= smp;
    last     <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    closes = welford_fold(smp, lst, res);
    if (closes) stats_expected_q.push_back(typed ? want : res);
    // bursts of random length, random gaps; now and then a stretch with no gaps
    if ($urandom_range(0, 79) == 0) gaps_on = !gaps_on;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // ---------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (stats_expected_q.size() == 0) begin
        $error("result with no expectation: variance %0d sample_count %0d overflow %0d",
               variance, sample_count, overflow);
        mismatches++;
      end else begin
        got_front = stats_expected_q.pop_front();
        if (variance !== got_front.variance) begin
          $error("variance: expected %0d, actual %0d", got_front.variance, variance);
          mismatches++;
        end
        if (sample_count !== got_front.cnt) begin
          $error("sample_count: expected %0d, actual %0d", got_front.cnt, sample_count);
          mismatches++;
        end
        if (overflow !== got_front.ovf) begin
          $error("overflow: expected %0d, actual %0d", got_front.ovf, overflow);
          mismatches++;
        end
      end
    end
  end

  // Hang detection: count cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      hang_cycles <= 0;
    end else begin
      hang_cycles <= hang_cycles + 1;
      if (hang_cycles >= HANG_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stall modes of its own, plus one long hold-off so the core
  // fills up and stalls its input while the sender keeps offering.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned period;
    int unsigned phase;
    bit          hold_done;
    mode      = 0;
    mode_left = 0;
    period    = 3;
    phase     = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 400);
          period    = $urandom_range(2, 7);
        end
        mode_left--;
        phase++;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 9) < 6);
          default: out_ready <= ((phase % period) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: directed table, then random sets.
  // ---------------------------------------------------------------------
  initial begin
    row_t                       rows[$];
    logic signed [SAMPLE_W-1:0] smp;
    logic signed [SAMPLE_W-1:0] base;
    int unsigned                set_len;
    int unsigned                style;
    int unsigned                pick;
    int                         sent;
    in_valid <= 1'b0;
    sample   <= '0;
    last     <= 1'b0;
    rst      <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // single-sample sets at the extremes and zero: variance 0, count 1
    rows.push_back({16'h8000, 1'b1, 1'b1, 46'd0, 19'd1, 1'b0});
    rows.push_back({16'h7FFF, 1'b1, 1'b1, 46'd0, 19'd1, 1'b0});
    rows.push_back({16'h0000, 1'b1, 1'b1, 46'd0, 19'd1, 1'b0});
    // min then max: variance (65535/2)^2 = 2^46 - 2^31 + 2^14 in Q.16
    rows.push_back({16'h8000, 1'b0, 1'b0, NONE});
    rows.push_back({16'h7FFF, 1'b1, 1'b1, 46'd70366596710400, 19'd2, 1'b0});
    // constant set: no spread
    rows.push_back({16'h0005, 1'b0, 1'b0, NONE});
    rows.push_back({16'h0005, 1'b0, 1'b0, NONE});
    rows.push_back({16'h0005, 1'b1, 1'b1, 46'd0, 19'd3, 1'b0});
    // +1, -1: variance 1.0
    rows.push_back({16'h0001, 1'b0, 1'b0, NONE});
    rows.push_back({16'hFFFF, 1'b1, 1'b1, 46'd65536, 19'd2, 1'b0});
    // mixed bit patterns, predictor-checked
    rows.push_back({16'h5555, 1'b0, 1'b0, NONE});
    rows.push_back({16'hAAAA, 1'b0, 1'b0, NONE});
    rows.push_back({16'h0100, 1'b0, 1'b0, NONE});
    rows.push_back({16'hFF00, 1'b0, 1'b0, NONE});
    rows.push_back({16'h1234, 1'b1, 1'b0, NONE});
    rows.push_back({16'h7FFF, 1'b0, 1'b0, NONE});
    rows.push_back({16'h7FFF, 1'b0, 1'b0, NONE});
    rows.push_back({16'h8000, 1'b0, 1'b0, NONE});
    rows.push_back({16'h0003, 1'b0, 1'b0, NONE});
    rows.push_back({16'hFFFD, 1'b0, 1'b0, NONE});
    rows.push_back({16'h4000, 1'b0, 1'b0, NONE});
    rows.push_back({16'hC000, 1'b1, 1'b0, NONE});

    foreach (rows[i]) push_sample(rows[i].smp, rows[i].lst, rows[i].typed, rows[i].want);

    // Random sets: mostly short, some medium, a few long, with varied content.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      set_len = $urandom_range(1, 6);
      else if (pick < 90) set_len = $urandom_range(7, 40);
      else                set_len = $urandom_range(41, 120);
      style = $urandom_range(0, 4);
      base  = 16'($urandom_range(0, 65535));
      for (int k = 0; k < set_len; k++) begin
        case (style)
          0:       smp = 16'($urandom_range(0, 65535));
          1:       smp = $signed(16'($urandom_range(0, 16))) - 16'sd8;
          2:       smp = base;
          3:       smp = ((k + $urandom_range(0, 1)) % 2 != 0) ? 16'sh7FFF : 16'sh8000;
          default: smp = base + ($signed(16'($urandom_range(0, 255))) - 16'sd128);
        endcase
        push_sample(smp, (k == set_len - 1), 1'b0, NONE);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (stats_expected_q.size() != 0) @(posedge clk);
    // wait past the last closing sample; catch anything spurious behind it
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
